// ===== design/vmt_pkg.sv =====
// vmt_pkg: shared types, codes and constants for the vertex matrix transform core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package vmt_pkg;

    localparam int VMT_DATA_W    = 32;  // width of one fixed-point component
    localparam int VMT_FRAC_BITS = 16;  // default fraction bits (Q16.16)
    localparam int VMT_NUM_REGS  = 8;
    localparam int VMT_IDX_W     = 3;
    localparam int VMT_CFG_W     = 64;

    // command codes
    localparam logic CMD_POINT  = 1'b0;
    localparam logic CMD_NORMAL = 1'b1;

    // status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_WZERO = 2'd1;
    localparam logic [1:0] STATUS_SAT   = 2'd2;

    // matrix register indexes
    localparam logic [VMT_IDX_W-1:0] REG_ROW0_COLS01 = 3'd0;
    localparam logic [VMT_IDX_W-1:0] REG_ROW0_COLS23 = 3'd1;
    localparam logic [VMT_IDX_W-1:0] REG_ROW1_COLS01 = 3'd2;
    localparam logic [VMT_IDX_W-1:0] REG_ROW1_COLS23 = 3'd3;
    localparam logic [VMT_IDX_W-1:0] REG_ROW2_COLS01 = 3'd4;
    localparam logic [VMT_IDX_W-1:0] REG_ROW2_COLS23 = 3'd5;
    localparam logic [VMT_IDX_W-1:0] REG_ROW3_COLS01 = 3'd6;
    localparam logic [VMT_IDX_W-1:0] REG_ROW3_COLS23 = 3'd7;

    // reset values: identity matrix in Q16.16
    localparam logic [VMT_CFG_W-1:0] RST_LOW_ONE  = 64'h0000_0000_0001_0000;
    localparam logic [VMT_CFG_W-1:0] RST_HIGH_ONE = 64'h0001_0000_0000_0000;
    localparam logic [VMT_CFG_W-1:0] RST_ZERO     = 64'h0;

    typedef struct packed {
        logic                         command;
        logic signed [VMT_DATA_W-1:0] in_x;
        logic signed [VMT_DATA_W-1:0] in_y;
        logic signed [VMT_DATA_W-1:0] in_z;
    } vmt_in_t;

    typedef struct packed {
        logic signed [VMT_DATA_W-1:0] out_x;
        logic signed [VMT_DATA_W-1:0] out_y;
        logic signed [VMT_DATA_W-1:0] out_z;
        logic [1:0]                   status;
    } vmt_out_t;

    // divider lane result
    typedef struct packed {
        logic                  ovf;  // quotient at or above 2^32
        logic                  neg;  // quotient sign
        logic [VMT_DATA_W-1:0] q;    // quotient magnitude
    } vmt_quo_t;

    // side data riding alongside the divider lanes
    typedef struct packed {
        logic                         cmd;
        logic                         wzero;
        logic                         nsat;
        logic signed [VMT_DATA_W-1:0] nx;
        logic signed [VMT_DATA_W-1:0] ny;
        logic signed [VMT_DATA_W-1:0] nz;
    } vmt_side_t;

endpackage

// ===== design/vmt_dot.sv =====
// vmt_dot: one column lane, three products then floored sum plus optional translation.
// Depends on vmt_pkg. Two register stages, advanced by en.
`timescale 1ns / 1ps

module vmt_dot
    import vmt_pkg::*;
#(
    parameter int FRAC_BITS = VMT_FRAC_BITS,
    localparam int DOT_W = 2 * VMT_DATA_W + 3 - FRAC_BITS
)(
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [VMT_DATA_W-1:0] vx,
    input  logic signed [VMT_DATA_W-1:0] vy,
    input  logic signed [VMT_DATA_W-1:0] vz,
    input  logic signed [VMT_DATA_W-1:0] m0,
    input  logic signed [VMT_DATA_W-1:0] m1,
    input  logic signed [VMT_DATA_W-1:0] m2,
    input  logic signed [VMT_DATA_W-1:0] trans,
    input  logic                         add,
    output logic signed [DOT_W-1:0]      dot
);

    localparam int P_W   = 2 * VMT_DATA_W;
    localparam int SUM_W = P_W + 2;
    localparam int FL_W  = SUM_W - FRAC_BITS;

    logic signed [P_W-1:0]        p0_next, p1_next, p2_next;
    logic signed [P_W-1:0]        p0_reg, p1_reg, p2_reg;
    logic signed [VMT_DATA_W-1:0] trans_reg;
    logic                         add_reg;
    logic signed [SUM_W-1:0]      sum;
    logic signed [FL_W-1:0]       floored;
    logic signed [DOT_W-1:0]      dot_next, dot_reg;

    assign p0_next = vx * m0;
    assign p1_next = vy * m1;
    assign p2_next = vz * m2;

    always_ff @(posedge clk) begin
        if (en)
        begin
            p0_reg    <= p0_next;
            p1_reg    <= p1_next;
            p2_reg    <= p2_next;
            trans_reg <= trans;
            add_reg   <= add;
        end
    end

    // exact sum, then arithmetic shift = floor
    assign sum      = SUM_W'(p0_reg) + SUM_W'(p1_reg) + SUM_W'(p2_reg);
    assign floored  = sum[SUM_W-1:FRAC_BITS];
    assign dot_next = DOT_W'(floored) + (add_reg ? DOT_W'(trans_reg) : '0);

    always_ff @(posedge clk) begin
        if (en)
        begin
            dot_reg <= dot_next;
        end
    end

    assign dot = dot_reg;

endmodule

// ===== design/vmt_div.sv =====
// vmt_div: pipelined restoring divider lane, (|num| << FRAC_BITS) / |den|.
// Depends on vmt_pkg. One setup stage then one quotient bit per stage.
`timescale 1ns / 1ps

module vmt_div
    import vmt_pkg::*;
#(
    parameter int FRAC_BITS = VMT_FRAC_BITS,
    localparam int DOT_W = 2 * VMT_DATA_W + 3 - FRAC_BITS
)(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [DOT_W-1:0] num,
    input  logic signed [DOT_W-1:0] den,
    output vmt_quo_t                quo
);

    localparam int QW  = VMT_DATA_W;
    localparam int N_W = DOT_W + FRAC_BITS;
    localparam int CW  = N_W + QW;

    logic [DOT_W-1:0] nm, dm;
    logic [N_W-1:0]   n_full;
    logic             ovf_next;

    logic [N_W-1:0]   r_reg   [QW+1];
    logic [DOT_W-1:0] d_reg   [QW+1];
    logic [QW-1:0]    q_reg   [QW+1];
    logic             neg_reg [QW+1];
    logic             ovf_reg [QW+1];

    assign nm       = num[DOT_W-1] ? (~num + 1'b1) : num;
    assign dm       = den[DOT_W-1] ? (~den + 1'b1) : den;
    assign n_full   = {nm, {FRAC_BITS{1'b0}}};
    assign ovf_next = CW'(n_full) >= (CW'(dm) << QW);

    always_ff @(posedge clk) begin
        if (en)
        begin
            r_reg[0]   <= n_full;
            d_reg[0]   <= dm;
            q_reg[0]   <= '0;
            neg_reg[0] <= num[DOT_W-1] ^ den[DOT_W-1];
            ovf_reg[0] <= ovf_next;
        end
    end

    for (genvar i = 0; i < QW; i++) begin : g_stage
        localparam int K = QW - 1 - i;
        logic [CW-1:0] dsh, rw;
        logic          take;

        assign dsh  = CW'(d_reg[i]) << K;
        assign rw   = CW'(r_reg[i]);
        assign take = rw >= dsh;

        always_ff @(posedge clk) begin
            if (en)
            begin
                r_reg[i+1]   <= take ? N_W'(rw - dsh) : r_reg[i];
                q_reg[i+1]   <= q_reg[i] | (take ? (QW'(1) << K) : '0);
                d_reg[i+1]   <= d_reg[i];
                neg_reg[i+1] <= neg_reg[i];
                ovf_reg[i+1] <= ovf_reg[i];
            end
        end
    end

    assign quo.ovf = ovf_reg[QW];
    assign quo.neg = neg_reg[QW];
    assign quo.q   = q_reg[QW];

endmodule

// ===== design/vertex_matrix_transform_core.sv =====
// vertex_matrix_transform_core: top level, matrix registers, lanes and merge stage.
// Depends on vmt_pkg, vmt_dot and vmt_div.
`timescale 1ns / 1ps

// Usage
//   Input words (command, in_x, in_y, in_z) arrive on src_valid/src_word and are
//   taken at an edge where src_valid is high and src_stall is low. Result words
//   (out_x, out_y, out_z, status) leave on dst_valid/dst_word and are taken at an
//   edge where dst_valid is high and dst_stall is low.
//   cfg_we/cfg_index/cfg_data write one 64-bit matrix register per edge; write
//   only while no word is in flight.
// Stages: from the accepting edge to dst_valid, the product stage captures the
//   word, then sum stage, divider setup, 32 divider bit stages, output register.
// Throughput: one word per cycle while not frozen. Four column lanes compute x, y,
//   z and w side by side; three divider lanes, each 32 stages deep, retire one
//   quotient bit per stage; the merge stage picks point or normal results and status.
// Reset: matrix returns to identity, all pipeline valid flags clear.
// Stall: the whole pipeline freezes only when the output register is full,
//   stalled, and the last stage holds a word; bubbles collapse otherwise, so a
//   new word can enter while a finished one waits.

module vertex_matrix_transform_core
    import vmt_pkg::*;
#(
    parameter int FRAC_BITS = VMT_FRAC_BITS
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    output logic                 src_stall,
    input  vmt_in_t              src_word,
    output logic                 dst_valid,
    input  logic                 dst_stall,
    output vmt_out_t             dst_word,
    input  logic                 cfg_we,
    input  logic [VMT_IDX_W-1:0] cfg_index,
    input  logic [VMT_CFG_W-1:0] cfg_data
);

    localparam int DOT_W  = 2 * VMT_DATA_W + 3 - FRAC_BITS;
    localparam int SIDE_N = VMT_DATA_W + 1;   // divider depth incl. setup
    localparam int DW     = VMT_DATA_W;

    // matrix registers
    logic [VMT_CFG_W-1:0]  m_reg [VMT_NUM_REGS];
    logic signed [DW-1:0]  ent   [4][4];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            m_reg[REG_ROW0_COLS01] <= RST_LOW_ONE;
            m_reg[REG_ROW0_COLS23] <= RST_ZERO;
            m_reg[REG_ROW1_COLS01] <= RST_HIGH_ONE;
            m_reg[REG_ROW1_COLS23] <= RST_ZERO;
            m_reg[REG_ROW2_COLS01] <= RST_ZERO;
            m_reg[REG_ROW2_COLS23] <= RST_LOW_ONE;
            m_reg[REG_ROW3_COLS01] <= RST_ZERO;
            m_reg[REG_ROW3_COLS23] <= RST_HIGH_ONE;
        end
        else if (cfg_we)
        begin
            m_reg[cfg_index] <= cfg_data;
        end
    end

    for (genvar r = 0; r < 4; r++) begin : g_row
        for (genvar c = 0; c < 4; c++) begin : g_col
            assign ent[r][c] = m_reg[r*2 + c/2][(c%2)*DW +: DW];
        end
    end

    // pipeline control
    logic                   pipe_en;
    logic                   v1_reg, v2_reg;
    logic                   cmd1_reg, cmd2_reg;
    logic                   sv_reg [SIDE_N];
    vmt_side_t              sd_reg [SIDE_N];
    logic                   last_valid;
    logic                   out_valid_reg;
    vmt_out_t               out_reg;

    assign last_valid = sv_reg[SIDE_N-1];
    assign pipe_en    = !(out_valid_reg && dst_stall && last_valid);
    assign src_stall  = !pipe_en;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            v1_reg <= src_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (pipe_en)
        begin
            cmd1_reg <= src_word.command;
            cmd2_reg <= cmd1_reg;
        end
    end

    // column lanes: x, y, z, w
    logic                    add_trans;
    logic signed [DOT_W-1:0] dot [4];

    assign add_trans = (src_word.command == CMD_POINT);

    for (genvar c = 0; c < 4; c++) begin : g_lane
        vmt_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
            .clk   (clk),
            .en    (pipe_en),
            .vx    (src_word.in_x),
            .vy    (src_word.in_y),
            .vz    (src_word.in_z),
            .m0    (ent[0][c]),
            .m1    (ent[1][c]),
            .m2    (ent[2][c]),
            .trans (ent[3][c]),
            .add   (add_trans),
            .dot   (dot[c])
        );
    end

    // normal-path saturation, done ahead of the divider
    logic          nsat_c [3];
    logic [DW-1:0] nval_c [3];
    vmt_side_t     side_next;

    for (genvar c = 0; c < 3; c++) begin : g_nsat
        logic [DOT_W-DW:0] top;
        assign top       = dot[c][DOT_W-1:DW-1];
        assign nsat_c[c] = !((&top) || !(|top));
        assign nval_c[c] = nsat_c[c] ? (dot[c][DOT_W-1] ? {1'b1, {(DW-1){1'b0}}}
                                                        : {1'b0, {(DW-1){1'b1}}})
                                     : dot[c][DW-1:0];
    end

    assign side_next.cmd   = cmd2_reg;
    assign side_next.wzero = (dot[3] == '0);
    assign side_next.nsat  = nsat_c[0] | nsat_c[1] | nsat_c[2];
    assign side_next.nx    = nval_c[0];
    assign side_next.ny    = nval_c[1];
    assign side_next.nz    = nval_c[2];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            for (int i = 0; i < SIDE_N; i++)
            begin
                sv_reg[i] <= 1'b0;
            end
        end
        else if (pipe_en)
        begin
            sv_reg[0] <= v2_reg;
            for (int i = 1; i < SIDE_N; i++)
            begin
                sv_reg[i] <= sv_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk) begin
        if (pipe_en)
        begin
            sd_reg[0] <= side_next;
            for (int i = 1; i < SIDE_N; i++)
            begin
                sd_reg[i] <= sd_reg[i-1];
            end
        end
    end

    // divider lanes
    vmt_quo_t quo [3];

    for (genvar c = 0; c < 3; c++) begin : g_div
        vmt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
            .clk (clk),
            .en  (pipe_en),
            .num (dot[c]),
            .den (dot[3]),
            .quo (quo[c])
        );
    end

    // merge: sign, saturation, status
    logic          psat_c [3];
    logic [DW-1:0] pval_c [3];
    vmt_side_t     sd_last;
    vmt_out_t      out_next;
    logic          any_sat;

    assign sd_last = sd_reg[SIDE_N-1];

    for (genvar c = 0; c < 3; c++) begin : g_merge
        assign psat_c[c] = quo[c].ovf || (quo[c].neg ? (quo[c].q[DW-1] && |quo[c].q[DW-2:0])
                                                     : quo[c].q[DW-1]);
        assign pval_c[c] = psat_c[c] ? (quo[c].neg ? {1'b1, {(DW-1){1'b0}}}
                                                   : {1'b0, {(DW-1){1'b1}}})
                                     : (quo[c].neg ? (~quo[c].q + 1'b1) : quo[c].q);
    end

    always_comb begin
        out_next = '0;
        any_sat  = 1'b0;
        if (sd_last.cmd == CMD_NORMAL)
        begin
            out_next.out_x = sd_last.nx;
            out_next.out_y = sd_last.ny;
            out_next.out_z = sd_last.nz;
            any_sat        = sd_last.nsat;
        end
        else if (!sd_last.wzero)
        begin
            out_next.out_x = pval_c[0];
            out_next.out_y = pval_c[1];
            out_next.out_z = pval_c[2];
            any_sat        = psat_c[0] | psat_c[1] | psat_c[2];
        end
        priority if (sd_last.cmd == CMD_POINT && sd_last.wzero)
            out_next.status = STATUS_WZERO;
        else if (any_sat)
            out_next.status = STATUS_SAT;
        else
            out_next.status = STATUS_OK;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            out_valid_reg <= last_valid || (out_valid_reg && dst_stall);
        end
    end

    always_ff @(posedge clk) begin
        if (pipe_en && last_valid)
        begin
            out_reg <= out_next;
        end
    end

    assign dst_valid = out_valid_reg;
    assign dst_word  = out_reg;

`ifndef SYNTHESIS
    // zero w always yields zero components
    a_wzero_clears: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_word.status == STATUS_WZERO |->
            dst_word.out_x == '0 && dst_word.out_y == '0 && dst_word.out_z == '0)
        else $error("w-zero result carries nonzero components");

    // frozen pipeline keeps its last stage
    a_freeze_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(sv_reg[SIDE_N-1]))
        else $error("last stage changed while pipeline frozen");

    // a frozen pipeline means a full, stalled output register
    a_freeze_cause: assert property (@(posedge clk) disable iff (!rst_n)
        src_stall |-> dst_valid && dst_stall)
        else $error("input stalled without output backpressure");
`endif

endmodule

// ===== sim/tb_top.sv =====
// tb_top: self-checking testbench for vertex_matrix_transform_core.
// Depends on vmt_pkg and the core; drives words with random idling and checks results.
`timescale 1ns / 1ps

module tb_top;
    import vmt_pkg::*;

    localparam int FRAC      = VMT_FRAC_BITS;
    localparam int LATENCY   = 35;
    localparam int HOLD_LEN  = 300;      // long receiver hold-off, in cycles
    localparam int CYC_LIMIT = 500000;
    localparam int PHASES    = 16;
    localparam int PHASE_LEN = 100;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic src_valid = 1'b0;
    logic src_stall;
    vmt_in_t src_word = '0;
    logic dst_valid;
    logic dst_stall = 1'b0;
    vmt_out_t dst_word;
    logic cfg_we = 1'b0;
    logic [VMT_IDX_W-1:0] cfg_index = '0;
    logic [VMT_CFG_W-1:0] cfg_data = '0;

    vertex_matrix_transform_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_word  (src_word),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_word  (dst_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // shadow copy of the matrix registers
    logic [VMT_CFG_W-1:0] matrix_regs [VMT_NUM_REGS];
    vmt_out_t expected_results [$];
    int  mismatches = 0;
    bit  calm = 1'b0;       // no idling on either side
    bit  hold_req = 1'b0;   // ask receiver for one long hold-off
    int  cycles = 0;

    typedef struct {
        vmt_in_t  word;
        bit       typed;    // expected result typed in below
        vmt_out_t res;
    } vector_row_t;

    vector_row_t directed [$];

    // matrix entry m[r][c]: even column in low half, odd in high half
    function automatic logic signed [31:0] entry(int r, int c);
        logic [63:0] reg_word;
        reg_word = matrix_regs[r * 2 + c / 2];
        return (c % 2) ? reg_word[63:32] : reg_word[31:0];
    endfunction

    // exact three-term dot product on column c, floored to FRAC fraction bits
    function automatic logic signed [71:0] dot_column(vmt_in_t w, int c);
        logic signed [71:0] vx, vy, vz, s;
        vx = w.in_x;
        vy = w.in_y;
        vz = w.in_z;
        s = vx * 72'(entry(0, c)) + vy * 72'(entry(1, c)) + vz * 72'(entry(2, c));
        return s >>> FRAC;
    endfunction

    function automatic logic signed [31:0] clamp32(logic signed [71:0] d, ref bit sat);
        if (d > 72'(Q_MAX))
        begin
            sat = 1'b1;
            return Q_MAX;
        end
        if (d < 72'(Q_MIN))
        begin
            sat = 1'b1;
            return Q_MIN;
        end
        return d[31:0];
    endfunction

    // (num << FRAC) / den on magnitudes, truncated toward zero, saturated
    function automatic logic signed [31:0] perspective_div(logic signed [71:0] num,
                                                           logic signed [71:0] den,
                                                           ref bit sat);
        logic [103:0] nm, dm, q;
        nm = (num < 0) ? 104'(-num) : 104'(num);
        dm = (den < 0) ? 104'(-den) : 104'(den);
        q = (nm << FRAC) / dm;
        if ((num < 0) != (den < 0))
        begin
            if (q > 104'h8000_0000)
            begin
                sat = 1'b1;
                return Q_MIN;
            end
            return 32'(-q);
        end
        if (q > 104'h7FFF_FFFF)
        begin
            sat = 1'b1;
            return Q_MAX;
        end
        return q[31:0];
    endfunction

    function automatic vmt_out_t transform_vertex(vmt_in_t w);
        vmt_out_t r;
        logic signed [71:0] hw;
        logic signed [31:0] comp [3];
        bit sat;
        sat = 1'b0;
        r.status = STATUS_OK;
        if (w.command == CMD_NORMAL)
        begin
            for (int c = 0; c < 3; c++)
                comp[c] = clamp32(dot_column(w, c), sat);
        end
        else
        begin
            hw = dot_column(w, 3) + 72'(entry(3, 3));
            if (hw == 0)
            begin
                comp[0] = '0; comp[1] = '0; comp[2] = '0;
                r.status = STATUS_WZERO;
            end
            else
            begin
                for (int c = 0; c < 3; c++)
                    comp[c] = perspective_div(dot_column(w, c) + 72'(entry(3, c)), hw, sat);
            end
        end
        if (r.status == STATUS_OK && sat)
            r.status = STATUS_SAT;
        r.out_x = comp[0];
        r.out_y = comp[1];
        r.out_z = comp[2];
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, field, got, want);
        mismatches++;
    endtask

    // result checker: compare each accepted word with the oldest expectation
    always @(posedge clk) begin
        vmt_out_t want;
        if (rst_n && dst_valid && !dst_stall)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected word", dst_word.out_x, '0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (dst_word.out_x !== want.out_x)
                    report_mismatch("out_x", dst_word.out_x, want.out_x);
                if (dst_word.out_y !== want.out_y)
                    report_mismatch("out_y", dst_word.out_y, want.out_y);
                if (dst_word.out_z !== want.out_z)
                    report_mismatch("out_z", dst_word.out_z, want.out_z);
                if (dst_word.status !== want.status)
                    report_mismatch("status", 32'(dst_word.status), 32'(want.status));
            end
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        forever
        begin
            if (hold_req)
            begin
                dst_stall <= 1'b1;
                repeat (HOLD_LEN) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                dst_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
            begin
                dst_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYC_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // offer one word, hold it until taken, then log what it should produce
    task automatic send_word(vmt_in_t w, bit typed, vmt_out_t typed_res);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            src_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_word  <= w;
        @(posedge clk);
        while (src_stall) @(posedge clk);
        expected_results.push_back(typed ? typed_res : transform_vertex(w));
    endtask

    task automatic drain();
        src_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    // one write, then cfg_we low again before returning, so back-to-back writes never collide
    task automatic write_matrix(logic [VMT_IDX_W-1:0] idx, logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        matrix_regs[idx] = value;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] random_component();
        case ($urandom_range(0, 7))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return Q_ONE * $signed($urandom_range(0, 8) - 4);
            4, 5:    return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] random_entry();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return Q_ONE;
            2:       return -Q_ONE;
            3:       return $urandom;
            default: return $signed($urandom_range(0, 32'h0007_FFFF)) - 32'sh0004_0000;
        endcase
    endfunction

    function automatic vmt_in_t random_word();
        vmt_in_t w;
        w.command = $urandom_range(0, 3) == 0 ? CMD_NORMAL : CMD_POINT;
        w.in_x = random_component();
        w.in_y = random_component();
        w.in_z = random_component();
        return w;
    endfunction

    function automatic vmt_in_t mk_word(logic cmd, logic [31:0] x, logic [31:0] y,
                                        logic [31:0] z);
        vmt_in_t w;
        w.command = cmd;
        w.in_x = x;
        w.in_y = y;
        w.in_z = z;
        return w;
    endfunction

    // identity matrix passes any vector straight through
    task automatic add_row(vmt_in_t w, bit typed);
        vector_row_t row;
        row.word  = w;
        row.typed = typed;
        row.res   = {w.in_x, w.in_y, w.in_z, STATUS_OK};
        directed.push_back(row);
    endtask

    initial begin
        logic [63:0] pick;
        vmt_out_t none;
        none = '0;
        matrix_regs[REG_ROW0_COLS01] = RST_LOW_ONE;
        matrix_regs[REG_ROW0_COLS23] = RST_ZERO;
        matrix_regs[REG_ROW1_COLS01] = RST_HIGH_ONE;
        matrix_regs[REG_ROW1_COLS23] = RST_ZERO;
        matrix_regs[REG_ROW2_COLS01] = RST_ZERO;
        matrix_regs[REG_ROW2_COLS23] = RST_LOW_ONE;
        matrix_regs[REG_ROW3_COLS01] = RST_ZERO;
        matrix_regs[REG_ROW3_COLS23] = RST_HIGH_ONE;

        // directed rows against the reset (identity) matrix
        add_row(mk_word(CMD_POINT,  '0, '0, '0), 1'b1);
        add_row(mk_word(CMD_NORMAL, '0, '0, '0), 1'b1);
        add_row(mk_word(CMD_POINT,  Q_MAX, Q_MIN, Q_ONE), 1'b1);
        add_row(mk_word(CMD_NORMAL, Q_MAX, Q_MIN, Q_ONE), 1'b1);
        add_row(mk_word(CMD_POINT,  Q_MIN, Q_MAX, -Q_ONE), 1'b1);
        add_row(mk_word(CMD_NORMAL, Q_MIN, Q_MIN, Q_MIN), 1'b1);
        add_row(mk_word(CMD_POINT,  32'hFFFF_FFFF, 32'h1, 32'hAAAA_5555), 1'b1);
        add_row(mk_word(CMD_NORMAL, 32'h5555_AAAA, 32'hFFFF_FFFF, 32'h1), 1'b1);
        add_row(mk_word(CMD_POINT,  Q_MAX, Q_MAX, Q_MAX), 1'b1);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_word(directed[i].word, directed[i].typed, directed[i].res);
        drain();

        // perspective matrix with a zero w bias: w hits zero, divide and saturation
        write_matrix(REG_ROW0_COLS23, {Q_ONE, 32'h0});   // m03 = 1.0
        write_matrix(REG_ROW3_COLS23, 64'h0);            // m33 = 0
        write_matrix(REG_ROW3_COLS01, {Q_ONE, -Q_ONE});
        send_word(mk_word(CMD_POINT, '0, Q_ONE, Q_ONE),
                  1'b1, {32'h0, 32'h0, 32'h0, STATUS_WZERO});
        send_word(mk_word(CMD_POINT, 32'h1, Q_MAX, Q_MIN), 1'b0, none);
        send_word(mk_word(CMD_POINT, -Q_ONE, 32'h0, 32'h0), 1'b0, none);
        send_word(mk_word(CMD_POINT, Q_MAX, 32'h0, 32'h0), 1'b0, none);
        send_word(mk_word(CMD_POINT, Q_MIN, Q_MAX, Q_MAX), 1'b0, none);
        send_word(mk_word(CMD_NORMAL, Q_MAX, Q_MAX, Q_MAX), 1'b0, none);
        send_word(mk_word(CMD_NORMAL, Q_MIN, Q_MIN, Q_MIN), 1'b0, none);
        drain();

        // random phases, each with its own matrix
        for (int p = 0; p < PHASES; p++)
        begin
            calm = (p >= PHASES - 2);
            for (int r = 0; r < VMT_NUM_REGS; r++)
            begin
                case (p)
                    0:       pick = {Q_MAX, Q_MAX};
                    1:       pick = {Q_MIN, Q_MIN};
                    2:       pick = 64'hFFFF_FFFF_FFFF_FFFF;
                    3:       pick = '0;
                    default: pick = {random_entry(), random_entry()};
                endcase
                // a w column of zeros makes every point hit the zero-w case
                if (p == 4 && (r % 2 == 1))
                    pick[63:32] = '0;
                write_matrix(r[VMT_IDX_W-1:0], pick);
            end
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                if (p == 5 && n == 10)
                    hold_req = 1'b1;            // sender keeps offering meanwhile
                if (p == 6 && n == 50)
                    drain();                    // sender waits for every result
                send_word(random_word(), 1'b0, none);
            end
            drain();
        end

        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
